// File: hdl/ftes_pkg.sv
// shared types, constants and arithmetic helpers for the two-electron scatter block
package ftes_pkg;

    localparam int NUM_BASIS     = 64;
    localparam int VALUE_WIDTH   = 48;
    localparam int FRACTION_BITS = 32;
    localparam int MAX_SYMMETRY  = 8;

    localparam int BW       = $clog2(NUM_BASIS);
    localparam int TRI_SIZE = NUM_BASIS * (NUM_BASIS + 1) / 2;
    localparam int IW       = 12;
    localparam int WW       = 4;
    localparam int PW       = 2 * VALUE_WIDTH;
    localparam int MH       = VALUE_WIDTH / 2;

    typedef logic signed [VALUE_WIDTH-1:0] val_t;
    typedef logic [IW-1:0]                 idx_t;
    typedef logic [BW-1:0]                 bas_t;
    typedef logic signed [PW-1:0]          wide_t;

    localparam val_t MAX_V   = val_t'({1'b0, {(VALUE_WIDTH-1){1'b1}}});
    localparam val_t MIN_V   = val_t'({1'b1, {(VALUE_WIDTH-1){1'b0}}});
    localparam val_t THIRD_Q = val_t'((64'd1 << FRACTION_BITS) / 3);
    localparam idx_t TRI_LAST = idx_t'(TRI_SIZE - 1);

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_ACC   = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    localparam logic [1:0] TGT_DC = 2'd0;
    localparam logic [1:0] TGT_DO = 2'd1;
    localparam logic [1:0] TGT_GC = 2'd2;
    localparam logic [1:0] TGT_GO = 2'd3;

    typedef struct packed {
        logic       item_load;
        logic       canon_load;
        logic       term_load;
        logic [1:0] term_sel;
        logic       mem_rd_item;
        logic       mem_wr_item;
        logic       hold_clear;
        logic       hold_capture;
        logic       upd_rd;
        logic [1:0] upd_sel;
        logic       mul_lo;
        logic       mul_hi;
        logic       mul_third;
        logic       prod_load;
        logic       ov_from_prod;
        logic       upd_wr;
        logic       clr_wr;
        idx_t       clr_addr;
        logic       out_load;
    } ftes_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       need_third;
        logic       last_term;
        logic       term_open;
    } ftes_sts_t;

    function automatic idx_t tri_idx(bas_t x, bas_t y);
        bas_t hi;
        bas_t lo;
        logic [2*BW:0] p;
        hi = (x >= y) ? x : y;
        lo = (x >= y) ? y : x;
        p = (2*BW+1)'(hi) * ((2*BW+1)'(hi) + (2*BW+1)'(1));
        return idx_t'(p >> 1) + idx_t'(lo);
    endfunction

    function automatic val_t sat_add(val_t a, val_t b);
        logic signed [VALUE_WIDTH:0] s;
        s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
        if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1])
            return s[VALUE_WIDTH] ? MIN_V : MAX_V;
        return s[VALUE_WIDTH-1:0];
    endfunction

    function automatic val_t sat_sub(val_t a, val_t b);
        logic signed [VALUE_WIDTH:0] s;
        s = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
        if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1])
            return s[VALUE_WIDTH] ? MIN_V : MAX_V;
        return s[VALUE_WIDTH-1:0];
    endfunction

    // floor shift of a full product, saturated
    function automatic val_t sat_prod(wide_t p);
        logic [PW-FRACTION_BITS-VALUE_WIDTH:0] top;
        top = p[PW-1:FRACTION_BITS+VALUE_WIDTH-1];
        if ((&top) || !(|top))
            return p[FRACTION_BITS+VALUE_WIDTH-1:FRACTION_BITS];
        return p[PW-1] ? MIN_V : MAX_V;
    endfunction

endpackage

// File: hdl/ftes_datapath.sv
// datapath: item registers, matrix memories, term setup, multiplier and saturating update
module ftes_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           mode,
    input  logic [1:0]           target,
    input  ftes_pkg::idx_t       pair_index,
    input  ftes_pkg::val_t       load_value,
    input  ftes_pkg::bas_t       basis_i,
    input  ftes_pkg::bas_t       basis_j,
    input  ftes_pkg::bas_t       basis_k,
    input  ftes_pkg::bas_t       basis_l,
    input  ftes_pkg::val_t       integral,
    input  logic [3:0]           symmetry_weight,
    input  logic                 shells_equivalent,
    input  ftes_pkg::ftes_cmd_t  cmd,
    output ftes_pkg::ftes_sts_t  sts,
    output ftes_pkg::val_t       read_data
);
    import ftes_pkg::*;

    localparam logic [1:0] CASE_EQ  = 2'd0;
    localparam logic [1:0] CASE_TWO = 2'd1;
    localparam logic [1:0] CASE_GEN = 2'd2;

    logic [1:0]    mode_reg, target_reg;
    idx_t          idx_reg;
    val_t          load_reg, integ_reg;
    bas_t          bi_reg, bj_reg, bk_reg, bl_reg;
    logic [WW-1:0] wt_reg;
    logic          eq_in_reg;

    bas_t ii_reg, jj_reg, kk_reg, ll_reg;
    val_t pk_reg;
    logic equiv_reg;

    idx_t a_reg, b_reg;
    val_t v_reg, ov_reg, prod_reg, hold_reg, read_data_reg;
    logic sub_reg, open_reg;
    wide_t acc_reg;

    val_t dc_mem [TRI_SIZE];
    val_t do_mem [TRI_SIZE];
    val_t gc_mem [TRI_SIZE];
    val_t go_mem [TRI_SIZE];
    val_t dc_q, do_q, gc_q, go_q;

    logic idx_ok;
    assign idx_ok = idx_reg <= TRI_LAST;

    // canonical ordering
    bas_t i1, j1, k1, l1;
    logic swap;
    logic [WW-1:0] wcl;
    logic signed [VALUE_WIDTH+WW:0] pkw;
    val_t pk_next;

    always_comb
    begin
        i1 = (bi_reg >= bj_reg) ? bi_reg : bj_reg;
        j1 = (bi_reg >= bj_reg) ? bj_reg : bi_reg;
        k1 = (bk_reg >= bl_reg) ? bk_reg : bl_reg;
        l1 = (bk_reg >= bl_reg) ? bl_reg : bk_reg;
        swap = tri_idx(i1, j1) < tri_idx(k1, l1);
        wcl = (wt_reg > WW'(MAX_SYMMETRY)) ? WW'(MAX_SYMMETRY) : wt_reg;
        pkw = integ_reg * $signed({1'b0, wcl});
        if ((&pkw[VALUE_WIDTH+WW:VALUE_WIDTH-1]) || !(|pkw[VALUE_WIDTH+WW:VALUE_WIDTH-1]))
            pk_next = pkw[VALUE_WIDTH-1:0];
        else
            pk_next = pkw[VALUE_WIDTH+WW] ? MIN_V : MAX_V;
    end

    // case and term table
    logic [1:0] case_code;
    logic       skip3;
    idx_t       ij, kl, ik, jl, il, kj, pa, pb;
    logic       t_num3, t_sub, t_open, t_third, t_last;
    logic [1:0] t_shift, vshift;
    logic signed [VALUE_WIDTH+1:0] vw, vs;
    val_t v_next;

    always_comb
    begin
        ij = tri_idx(ii_reg, jj_reg);
        kl = tri_idx(kk_reg, ll_reg);
        ik = tri_idx(ii_reg, kk_reg);
        jl = tri_idx(jj_reg, ll_reg);
        il = tri_idx(ii_reg, ll_reg);
        kj = tri_idx(kk_reg, jj_reg);
        skip3 = equiv_reg && (ii_reg == jj_reg || kk_reg == ll_reg);
        if (jj_reg == kk_reg && skip3)
            case_code = CASE_EQ;
        else if (jj_reg == kk_reg || ii_reg == kk_reg || jj_reg == ll_reg)
            case_code = CASE_TWO;
        else
            case_code = CASE_GEN;

        pa = ij;
        pb = kl;
        t_num3 = 1'b0;
        t_shift = 2'd0;
        t_sub = 1'b0;
        t_open = 1'b0;
        t_third = 1'b0;
        t_last = 1'b1;
        unique case (case_code)
            CASE_EQ:
            begin
                t_shift = 2'd1;
                t_open = 1'b1;
            end
            CASE_TWO:
            begin
                t_open = 1'b1;
                if (cmd.term_sel == 2'd0)
                begin
                    t_num3 = 1'b1;
                    t_shift = 2'd2;
                    t_third = 1'b1;
                    t_last = 1'b0;
                end
                else
                begin
                    pa = (jj_reg == kk_reg) ? il : ik;
                    pb = (jj_reg == kk_reg) ? kj : jl;
                    t_shift = 2'd1;
                    t_sub = 1'b1;
                end
            end
            default:
            begin
                if (cmd.term_sel == 2'd0)
                    t_last = 1'b0;
                else if (cmd.term_sel == 2'd1)
                begin
                    pa = ik;
                    pb = jl;
                    t_shift = 2'd2;
                    t_sub = 1'b1;
                    t_open = 1'b1;
                    t_last = skip3;
                end
                else
                begin
                    pa = il;
                    pb = kj;
                    t_shift = 2'd2;
                    t_sub = 1'b1;
                    t_open = 1'b1;
                end
            end
        endcase

        // halve for an equal pair of equivalent shells
        vshift = t_shift + 2'((equiv_reg && pa == pb) ? 1 : 0);
        vw = {{2{pk_reg[VALUE_WIDTH-1]}}, pk_reg}
           + (t_num3 ? {pk_reg[VALUE_WIDTH-1], pk_reg, 1'b0} : '0);
        vs = vw >>> vshift;
        v_next = vs[VALUE_WIDTH-1:0];
    end

    assign sts.mode       = mode_reg;
    assign sts.need_third = t_third;
    assign sts.last_term  = t_last;
    assign sts.term_open  = open_reg;

    // update addressing
    idx_t x_addr, y_addr, d_ra, g_ra;
    logic open_side;
    assign open_side = cmd.upd_sel[1];
    assign x_addr = cmd.upd_sel[0] ? b_reg : a_reg;
    assign y_addr = cmd.upd_sel[0] ? a_reg : b_reg;
    assign d_ra = cmd.upd_rd ? y_addr : idx_reg;
    assign g_ra = cmd.upd_rd ? x_addr : idx_reg;

    logic item_rd;
    assign item_rd = cmd.mem_rd_item && idx_ok;

    // multiplier: two half-width passes
    val_t ma, mb;
    logic signed [VALUE_WIDTH+MH:0]       pl;
    logic signed [2*VALUE_WIDTH-MH-1:0]   ph;
    val_t prod_sat, g_old, g_new;

    always_comb
    begin
        ma = cmd.mul_third ? v_reg : (open_side ? do_q : dc_q);
        mb = cmd.mul_third ? THIRD_Q : (open_side ? ov_reg : v_reg);
        pl = ma * $signed({1'b0, mb[MH-1:0]});
        ph = ma * $signed(mb[VALUE_WIDTH-1:MH]);
        prod_sat = sat_prod(acc_reg);
        g_old = open_side ? go_q : gc_q;
        g_new = (sub_reg && !open_side) ? sat_sub(g_old, prod_reg) : sat_add(g_old, prod_reg);
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr_item && idx_ok && target_reg == TGT_DC)
            dc_mem[idx_reg] <= load_reg;
        if (item_rd || (cmd.upd_rd && !open_side))
            dc_q <= dc_mem[d_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr_item && idx_ok && target_reg == TGT_DO)
            do_mem[idx_reg] <= load_reg;
        if (item_rd || (cmd.upd_rd && open_side))
            do_q <= do_mem[d_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
            gc_mem[cmd.clr_addr] <= '0;
        else if (cmd.upd_wr && !open_side)
            gc_mem[x_addr] <= g_new;
        else if (cmd.mem_wr_item && idx_ok && target_reg == TGT_GC)
            gc_mem[idx_reg] <= load_reg;
        if (item_rd || (cmd.upd_rd && !open_side))
            gc_q <= gc_mem[g_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
            go_mem[cmd.clr_addr] <= '0;
        else if (cmd.upd_wr && open_side)
            go_mem[x_addr] <= g_new;
        else if (cmd.mem_wr_item && idx_ok && target_reg == TGT_GO)
            go_mem[idx_reg] <= load_reg;
        if (item_rd || (cmd.upd_rd && open_side))
            go_q <= go_mem[g_ra];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            mode_reg   <= mode;
            target_reg <= target;
            idx_reg    <= pair_index;
            load_reg   <= load_value;
            bi_reg     <= basis_i;
            bj_reg     <= basis_j;
            bk_reg     <= basis_k;
            bl_reg     <= basis_l;
            integ_reg  <= integral;
            wt_reg     <= symmetry_weight;
            eq_in_reg  <= shells_equivalent;
        end
        if (cmd.canon_load)
        begin
            ii_reg    <= swap ? k1 : i1;
            jj_reg    <= swap ? l1 : j1;
            kk_reg    <= swap ? i1 : k1;
            ll_reg    <= swap ? j1 : l1;
            pk_reg    <= pk_next;
            equiv_reg <= eq_in_reg;
        end
        if (cmd.term_load)
        begin
            a_reg    <= pa;
            b_reg    <= pb;
            v_reg    <= v_next;
            ov_reg   <= v_next;
            sub_reg  <= t_sub;
            open_reg <= t_open;
        end
        else if (cmd.ov_from_prod)
            ov_reg <= prod_sat;
        if (cmd.mul_lo)
            acc_reg <= {{(PW-VALUE_WIDTH-MH-1){pl[VALUE_WIDTH+MH]}}, pl};
        else if (cmd.mul_hi)
            acc_reg <= acc_reg + {ph, {MH{1'b0}}};
        if (cmd.prod_load)
            prod_reg <= prod_sat;
        if (cmd.hold_clear)
            hold_reg <= '0;
        else if (cmd.hold_capture && idx_ok)
        begin
            unique case (target_reg)
                TGT_DC:  hold_reg <= dc_q;
                TGT_DO:  hold_reg <= do_q;
                TGT_GC:  hold_reg <= gc_q;
                default: hold_reg <= go_q;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            read_data_reg <= '0;
        else if (cmd.out_load)
            read_data_reg <= hold_reg;
    end

    assign read_data = read_data_reg;

endmodule

// File: hdl/ftes_ctrl.sv
// controller: clearing pass, item sequencing over terms and updates, handshakes
module ftes_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data,
    input  ftes_pkg::ftes_sts_t  sts,
    output ftes_pkg::ftes_cmd_t  cmd
);
    import ftes_pkg::*;

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_DECODE = 5'd2;
    localparam logic [4:0] S_RDOUT  = 5'd3;
    localparam logic [4:0] S_CANON  = 5'd4;
    localparam logic [4:0] S_TERM   = 5'd5;
    localparam logic [4:0] S_THIRD0 = 5'd6;
    localparam logic [4:0] S_THIRD1 = 5'd7;
    localparam logic [4:0] S_THIRD2 = 5'd8;
    localparam logic [4:0] S_UPD_RD = 5'd9;
    localparam logic [4:0] S_UPD_M0 = 5'd10;
    localparam logic [4:0] S_UPD_M1 = 5'd11;
    localparam logic [4:0] S_UPD_PR = 5'd12;
    localparam logic [4:0] S_UPD_WR = 5'd13;
    localparam logic [4:0] S_DONE   = 5'd14;

    logic [4:0] state_reg, state_next;
    idx_t       clr_cnt_reg, clr_cnt_next;
    logic [1:0] term_sel_reg, term_sel_next;
    logic [1:0] upd_cnt_reg, upd_cnt_next;
    logic       osen_reg;
    logic       out_valid_reg, out_valid_next;
    logic       upd_done, slot_free;

    assign upd_done = (upd_cnt_reg == 2'd3)
                   || (upd_cnt_reg == 2'd1 && !(sts.term_open && osen_reg));
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        clr_cnt_next = clr_cnt_reg;
        term_sel_next = term_sel_reg;
        upd_cnt_next = upd_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd = '0;
        cmd.term_sel = term_sel_reg;
        cmd.upd_sel = upd_cnt_reg;
        cmd.clr_addr = clr_cnt_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                clr_cnt_next = clr_cnt_reg + idx_t'(1);
                if (clr_cnt_reg == TRI_LAST)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.hold_clear = 1'b1;
                unique case (sts.mode)
                    MODE_LOAD:
                    begin
                        cmd.mem_wr_item = 1'b1;
                        state_next = S_DONE;
                    end
                    MODE_READ:
                    begin
                        cmd.mem_rd_item = 1'b1;
                        state_next = S_RDOUT;
                    end
                    MODE_ACC:  state_next = S_CANON;
                    default:   state_next = S_DONE;
                endcase
            end
            S_RDOUT:
            begin
                cmd.hold_capture = 1'b1;
                state_next = S_DONE;
            end
            S_CANON:
            begin
                cmd.canon_load = 1'b1;
                term_sel_next = 2'd0;
                state_next = S_TERM;
            end
            S_TERM:
            begin
                cmd.term_load = 1'b1;
                upd_cnt_next = 2'd0;
                state_next = sts.need_third ? S_THIRD0 : S_UPD_RD;
            end
            S_THIRD0:
            begin
                cmd.mul_third = 1'b1;
                cmd.mul_lo = 1'b1;
                state_next = S_THIRD1;
            end
            S_THIRD1:
            begin
                cmd.mul_third = 1'b1;
                cmd.mul_hi = 1'b1;
                state_next = S_THIRD2;
            end
            S_THIRD2:
            begin
                cmd.ov_from_prod = 1'b1;
                state_next = S_UPD_RD;
            end
            S_UPD_RD:
            begin
                cmd.upd_rd = 1'b1;
                state_next = S_UPD_M0;
            end
            S_UPD_M0:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_UPD_M1;
            end
            S_UPD_M1:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_UPD_PR;
            end
            S_UPD_PR:
            begin
                cmd.prod_load = 1'b1;
                state_next = S_UPD_WR;
            end
            S_UPD_WR:
            begin
                cmd.upd_wr = 1'b1;
                if (!upd_done)
                begin
                    upd_cnt_next = upd_cnt_reg + 2'd1;
                    state_next = S_UPD_RD;
                end
                else if (sts.last_term)
                    state_next = S_DONE;
                else
                begin
                    term_sel_next = term_sel_reg + 2'd1;
                    state_next = S_TERM;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            term_sel_reg  <= '0;
            upd_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            osen_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            term_sel_reg  <= term_sel_next;
            upd_cnt_reg   <= upd_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
                osen_reg <= cfg_data;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign cfg_ready = 1'b1;

endmodule

// File: hdl/fock_two_electron_scatter.sv
// top level of the two-electron scatter block: controller plus datapath
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_stall    mode .. shells_equivalent
//  out       output     out_valid / out_stall  read_data
//  cfg       input      cfg_valid / cfg_ready  cfg_data (open_shell_enable)
//
// load and ignored modes pass DECODE, DONE; read DECODE, RDOUT, DONE; accumulate
// DECODE, CANON, then per term TERM (plus THIRD0 to THIRD2 for the one-third
// scaling) and per matrix update UPD_RD, UPD_M0, UPD_M1, UPD_PR and UPD_WR;
// one transaction at a time; a new item is taken while a result waits on out
// after reset a clearing pass zeroes both G matrices, in_stall high
module fock_two_electron_scatter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           mode,
    input  logic [1:0]           target,
    input  ftes_pkg::idx_t       pair_index,
    input  ftes_pkg::val_t       load_value,
    input  ftes_pkg::bas_t       basis_i,
    input  ftes_pkg::bas_t       basis_j,
    input  ftes_pkg::bas_t       basis_k,
    input  ftes_pkg::bas_t       basis_l,
    input  ftes_pkg::val_t       integral,
    input  logic [3:0]           symmetry_weight,
    input  logic                 shells_equivalent,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ftes_pkg::val_t       read_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);
    import ftes_pkg::*;

    ftes_cmd_t cmd;
    ftes_sts_t sts;

    ftes_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .sts       (sts),
        .cmd       (cmd)
    );

    ftes_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .mode              (mode),
        .target            (target),
        .pair_index        (pair_index),
        .load_value        (load_value),
        .basis_i           (basis_i),
        .basis_j           (basis_j),
        .basis_k           (basis_k),
        .basis_l           (basis_l),
        .integral          (integral),
        .symmetry_weight   (symmetry_weight),
        .shells_equivalent (shells_equivalent),
        .cmd               (cmd),
        .sts               (sts),
        .read_data         (read_data)
    );

endmodule

// File: hdl/ftes_checker.sv
// port-level checker for the two-electron scatter block and its bind
module ftes_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall
);

    // one transaction in flight at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is in progress");

    // a new result only follows a cycle with the input side busy
    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an item in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled result dropped");

endmodule

bind fock_two_electron_scatter ftes_checker u_ftes_checker (.*);
